### rtl/ffba_pkg.sv
// ---------------------------------------------------------------------------
// ffba_pkg
// Shared types, sizes and codes of the first-fit block allocator.
// ---------------------------------------------------------------------------
package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 24;
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 32;
    localparam int CTR_W        = 32;
    localparam int HEAP_W       = ADDR_W + 1;   // heap top may sit one past the address space
    localparam int LAST_W       = ADDR_W + 2;   // last byte of a block being appended
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_DATA_W    = 64;
    localparam int OUT_DATA_W   = 136;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        ST_OK,
        ST_ZERO,
        ST_HEAP,
        ST_TABLE,
        ST_UNKNOWN,
        ST_TWICE
    } status_t;

    typedef enum logic [1:0] {
        TAG_FRESH,
        TAG_REUSED,
        TAG_RELEASED
    } tag_t;

    typedef enum logic {
        REQ_ALLOC,
        REQ_RELEASE
    } req_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MISS,
        S_DONE
    } state_t;

    // One table entry; the payload address is kept instead of the block start.
    typedef struct packed {
        logic [ADDR_W-1:0] payload;
        logic [SIZE_W-1:0] size;
        logic              released;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } tbl_wr_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic              base_wr;
        logic [ADDR_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] payload;
        tag_t              tag;
        logic [CTR_W-1:0]  alloc_cnt;
        logic [CTR_W-1:0]  release_cnt;
    } result_t;

endpackage

### rtl/first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator with a fixed table of blocks in address
// order; handles allocate and release requests and reports running counts.
// ---------------------------------------------------------------------------
//
//  channel   direction  beat carries
//  s_        in         request: type in tuser, size and address in tdata
//  m_        out        result: status, payload, tag and the three counts
//  cfg_      in         register write: index and 32-bit data
//
//  A request is taken in idle. An allocate of size zero goes straight to
//  done; any other request scans until an entry hits (then done), or, when
//  none of the n entries hits or the table is empty, goes via miss to
//  done: the table RAM is read one entry a cycle.
//  Reset clears the block count, heap top, counts and both handshakes;
//  table contents need no clearing since only filled entries are compared.
//  A stalled result waits in the output register while the next request
//  is taken and scanned; the scan holds once a second result is ready.
//
module first_fit_block_allocator import ffba_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // size[31:0], address[63:32]
    input  logic                  s_tuser,   // req_type[0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // status[2:0], payload_address[34:3],
                                             // block_tag[36:35], alloc_total[68:37],
                                             // release_total[100:69],
                                             // leak_total[132:101], zero[135:133]
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [ADDR_W-1:0]     limit_reg;
    cfg_t                  cfg;

    logic                  res_valid;
    logic                  res_ready;
    result_t               res;
    logic [CTR_W-1:0]      leak;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    tbl_wr_t               tbl_wr;
    logic                  tbl_rd_en;
    logic [IDX_W-1:0]      tbl_rd_addr;
    entry_t                tbl_rd_data;

    // registers are always writable; user must write only while idle, not enforced
    assign cfg_ready   = 1'b1;
    assign cfg.base    = cfg_data;
    assign cfg.base_wr = cfg_valid && (cfg_index == CFG_HEAP_BASE);
    assign cfg.limit   = limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '1;
        end else if (cfg_valid && (cfg_index == CFG_HEAP_LIMIT)) begin
            limit_reg <= cfg_data;
        end
    end

    ffba_table u_table (
        .aclk    (aclk),
        .wr      (tbl_wr),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    ffba_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_req      (req_t'(s_tuser)),
        .in_size     (s_tdata[SIZE_W-1:0]),
        .in_addr     (s_tdata[IN_DATA_W-1:SIZE_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .tbl_wr      (tbl_wr),
        .tbl_rd_en   (tbl_rd_en),
        .tbl_rd_addr (tbl_rd_addr),
        .tbl_rd_data (tbl_rd_data)
    );

    // blocks still held; clamp at zero once releases pull ahead of saturated allocs
    assign leak = (res.alloc_cnt >= res.release_cnt)
                  ? res.alloc_cnt - res.release_cnt : '0;

    // output register: take a new result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, leak, res.release_cnt, res.alloc_cnt,
                              res.tag, res.payload, res.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/ffba_table.sv
// ---------------------------------------------------------------------------
// ffba_table
// Block table: one write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ffba_table import ffba_pkg::*; (
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ffba_scan.sv
// ---------------------------------------------------------------------------
// ffba_scan
// Request sequencer: walks the table one entry a cycle, then updates the
// hit entry or appends a new block, and keeps heap top and success counts.
// ---------------------------------------------------------------------------
module ffba_scan import ffba_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  req_t              in_req,
    input  logic [SIZE_W-1:0] in_size,
    input  logic [ADDR_W-1:0] in_addr,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    output tbl_wr_t           tbl_wr,
    output logic              tbl_rd_en,
    output logic [IDX_W-1:0]  tbl_rd_addr,
    input  entry_t            tbl_rd_data
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [HEAP_W-1:0]   heap_top_reg, heap_top_next;
    logic [CTR_W-1:0]    alloc_reg, alloc_next;
    logic [CTR_W-1:0]    release_reg, release_next;
    req_t                req_reg, req_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [LAST_W-1:0]   last_reg, last_next;
    result_t             res_reg, res_next;

    logic [CNT_W-1:0]    idx_inc;
    logic                hit;
    logic                scan_end;
    logic                heap_over;
    logic                table_full;
    logic                zero_alloc;
    logic [CTR_W-1:0]    alloc_sat;
    logic [CTR_W-1:0]    release_sat;

    assign idx_inc     = {1'b0, idx_reg} + CNT_W'(1);
    assign scan_end    = (idx_inc == count_reg);
    assign hit         = (req_reg == REQ_ALLOC)
                         ? (tbl_rd_data.released && (tbl_rd_data.size >= size_reg))
                         : (tbl_rd_data.payload == addr_reg);
    assign heap_over   = last_reg > LAST_W'(cfg.limit);
    assign table_full  = (count_reg == CNT_W'(MAX_BLOCKS));
    assign zero_alloc  = (in_req == REQ_ALLOC) && (in_size == '0);
    assign alloc_sat   = (alloc_reg == '1) ? alloc_reg : alloc_reg + CTR_W'(1);
    assign release_sat = (release_reg == '1) ? release_reg : release_reg + CTR_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (zero_alloc) begin
                        state_next = S_DONE;
                    end else if (count_reg == '0) begin
                        state_next = S_MISS;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    state_next = S_DONE;
                end else if (scan_end) begin
                    state_next = S_MISS;
                end
            end
            S_MISS: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        tbl_rd_en     = 1'b0;
        tbl_rd_addr   = idx_inc[IDX_W-1:0];
        tbl_wr        = '0;
        idx_next      = idx_reg;
        count_next    = count_reg;
        heap_top_next = heap_top_reg;
        alloc_next    = alloc_reg;
        release_next  = release_reg;
        req_next      = req_reg;
        size_next     = size_reg;
        addr_next     = addr_reg;
        last_next     = last_reg;
        res_next      = res_reg;

        // a new heap base drags the heap top along while the table is empty
        if (cfg.base_wr && (count_reg == '0)) begin
            heap_top_next = HEAP_W'(cfg.base);
        end

        unique case (state_reg)
            S_IDLE: begin
                in_ready    = 1'b1;
                tbl_rd_en   = 1'b1;
                tbl_rd_addr = '0;
                if (in_valid) begin
                    req_next  = in_req;
                    size_next = in_size;
                    addr_next = in_addr;
                    idx_next  = '0;
                    last_next = LAST_W'(heap_top_reg) + LAST_W'(HEADER_BYTES)
                                + LAST_W'(in_size) - LAST_W'(1);
                    res_next  = '{status: ST_ZERO, payload: '0, tag: TAG_FRESH,
                                  alloc_cnt: alloc_reg, release_cnt: release_reg};
                end
            end
            S_SCAN: begin
                tbl_rd_en = 1'b1;
                idx_next  = idx_inc[IDX_W-1:0];
                if (hit) begin
                    tbl_wr.addr = idx_reg;
                    tbl_wr.data = tbl_rd_data;
                    if (req_reg == REQ_ALLOC) begin
                        tbl_wr.en            = 1'b1;
                        tbl_wr.data.released = 1'b0;
                        alloc_next           = alloc_sat;
                        res_next = '{status: ST_OK, payload: tbl_rd_data.payload,
                                     tag: TAG_REUSED, alloc_cnt: alloc_sat,
                                     release_cnt: release_reg};
                    end else if (tbl_rd_data.released) begin
                        res_next = '{status: ST_TWICE, payload: '0, tag: TAG_RELEASED,
                                     alloc_cnt: alloc_reg, release_cnt: release_reg};
                    end else begin
                        tbl_wr.en            = 1'b1;
                        tbl_wr.data.released = 1'b1;
                        release_next         = release_sat;
                        res_next = '{status: ST_OK, payload: addr_reg, tag: TAG_RELEASED,
                                     alloc_cnt: alloc_reg, release_cnt: release_sat};
                    end
                end
            end
            S_MISS: begin
                if (req_reg == REQ_RELEASE) begin
                    res_next = '{status: (addr_reg == '0) ? ST_OK : ST_UNKNOWN,
                                 payload: '0, tag: TAG_FRESH,
                                 alloc_cnt: alloc_reg, release_cnt: release_reg};
                end else if (heap_over) begin
                    res_next = '{status: ST_HEAP, payload: '0, tag: TAG_FRESH,
                                 alloc_cnt: alloc_reg, release_cnt: release_reg};
                end else if (table_full) begin
                    res_next = '{status: ST_TABLE, payload: '0, tag: TAG_FRESH,
                                 alloc_cnt: alloc_reg, release_cnt: release_reg};
                end else begin
                    // append a fresh block at the heap top
                    tbl_wr.en            = 1'b1;
                    tbl_wr.addr          = count_reg[IDX_W-1:0];
                    tbl_wr.data.payload  = heap_top_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    tbl_wr.data.size     = size_reg;
                    tbl_wr.data.released = 1'b0;
                    count_next           = count_reg + CNT_W'(1);
                    heap_top_next        = HEAP_W'(last_reg + LAST_W'(1));
                    alloc_next           = alloc_sat;
                    res_next = '{status: ST_OK,
                                 payload: heap_top_reg[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES),
                                 tag: TAG_FRESH, alloc_cnt: alloc_sat,
                                 release_cnt: release_reg};
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            heap_top_reg <= '0;
            alloc_reg    <= '0;
            release_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            heap_top_reg <= heap_top_next;
            alloc_reg    <= alloc_next;
            release_reg  <= release_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        req_reg  <= req_next;
        size_reg <= size_next;
        addr_reg <= addr_next;
        last_reg <= last_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit block allocator: directed requests
// around the empty heap, first-fit reuse and the heap limit, then random
// allocate/release churn under three limit settings, all checked beat by
// beat against a local predictor of the block table.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ffba_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 100;

    // Fields of one result beat, as the predictor works them out
    typedef struct {
        status_t           status;
        logic [ADDR_W-1:0] payload;
        tag_t              tag;
        logic [CTR_W-1:0]  alloc_total;
        logic [CTR_W-1:0]  release_total;
        logic [CTR_W-1:0]  leak_total;
    } outcome_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // size[31:0], address[63:32]
    logic                  s_tuser   = 1'b0; // req_type[0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // status, payload, tag, alloc, release, leak
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predictor copy of the registers and the block table
    logic [ADDR_W-1:0]     heap_base_q;
    logic [ADDR_W-1:0]     heap_limit_q;
    logic [ADDR_W-1:0]     blk_start [MAX_BLOCKS];
    logic [SIZE_W-1:0]     blk_size  [MAX_BLOCKS];
    bit                    blk_freed [MAX_BLOCKS];
    int                    blk_count;
    logic [HEAP_W-1:0]     heap_top_q;
    logic [CTR_W-1:0]      allocs_q;
    logic [CTR_W-1:0]      releases_q;

    outcome_t              outcome_q [$];

    bit                    no_gaps;
    int                    stall_left;
    int                    err_count;
    int                    requests_sent;
    int                    results_seen;
    int                    status_seen [6];
    int                    cycle_count;

    first_fit_block_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    // Payload address of a table block: the start plus its header
    function automatic logic [ADDR_W-1:0] payload_at(int k);
        return blk_start[k] + ADDR_W'(HEADER_BYTES);
    endfunction

    function automatic logic [CTR_W-1:0] bump(logic [CTR_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Work out the result of one request and advance the table state
    function automatic outcome_t heap_outcome(req_t kind, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] addr);
        outcome_t          r;
        int                hit;
        int                i;
        logic [LAST_W-1:0] last;
        r.status  = ST_OK;
        r.payload = '0;
        r.tag     = TAG_FRESH;
        hit       = -1;
        if (kind == REQ_ALLOC) begin
            if (size == '0) begin
                r.status = ST_ZERO;
            end else begin
                // first released block that is big enough
                for (i = 0; i < blk_count; i++)
                    if (hit < 0 && blk_freed[i] && blk_size[i] >= size) hit = i;
                if (hit >= 0) begin
                    blk_freed[hit] = 1'b0;
                    r.payload      = payload_at(hit);
                    r.tag          = TAG_REUSED;
                    allocs_q       = bump(allocs_q);
                end else begin
                    // append at the heap top; heap room is judged before table room
                    last = LAST_W'(heap_top_q) + LAST_W'(HEADER_BYTES) + LAST_W'(size)
                           - LAST_W'(1);
                    if (last > LAST_W'(heap_limit_q)) begin
                        r.status = ST_HEAP;
                    end else if (blk_count >= MAX_BLOCKS) begin
                        r.status = ST_TABLE;
                    end else begin
                        blk_start[blk_count] = heap_top_q[ADDR_W-1:0];
                        blk_size[blk_count]  = size;
                        blk_freed[blk_count] = 1'b0;
                        r.payload            = payload_at(blk_count);
                        blk_count++;
                        heap_top_q = HEAP_W'(last + LAST_W'(1));
                        allocs_q   = bump(allocs_q);
                    end
                end
            end
        end else begin
            for (i = 0; i < blk_count; i++)
                if (hit < 0 && payload_at(i) == addr) hit = i;
            if (hit < 0) begin
                // an unmatched null pointer is silently ignored
                r.status = (addr == '0) ? ST_OK : ST_UNKNOWN;
            end else if (blk_freed[hit]) begin
                r.status = ST_TWICE;
                r.tag    = TAG_RELEASED;
            end else begin
                blk_freed[hit] = 1'b1;
                r.payload      = addr;
                r.tag          = TAG_RELEASED;
                releases_q     = bump(releases_q);
            end
        end
        r.alloc_total   = allocs_q;
        r.release_total = releases_q;
        r.leak_total    = (allocs_q >= releases_q) ? allocs_q - releases_q : '0;
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Gap length for either side: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request beat, hold it until taken, then queue its outcome
    task automatic send_req(req_t kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {addr, size};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcome_q.push_back(heap_outcome(kind, size, addr));
        requests_sent++;
    endtask

    // Stop offering and wait until every outstanding result has come back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outcome_q.size() != 0);
    endtask

    // Register write, only ever issued with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEAP_BASE) begin
            heap_base_q = value;
            // the base only drags the heap top along while the table is empty
            if (blk_count == 0) heap_top_q = HEAP_W'(value);
        end else if (idx == CFG_HEAP_LIMIT) begin
            heap_limit_q = value;
        end
    endtask

    // Random churn: mostly well-aimed allocates and releases, some noise
    task automatic random_requests(int n);
        int                held [$];
        int                freed [$];
        int                i;
        int                k;
        int                r;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        for (int j = 0; j < n; j++) begin
            held.delete();
            freed.delete();
            for (i = 0; i < blk_count; i++)
                if (blk_freed[i]) freed.push_back(i); else held.push_back(i);
            // the unused field of each beat carries random noise
            size = $urandom;
            addr = $urandom;
            r    = $urandom_range(0, 99);
            if (r < 50) begin
                r = $urandom_range(0, 99);
                if (r < 35 && freed.size() > 0) begin
                    k    = freed[$urandom_range(0, freed.size() - 1)];
                    size = $urandom_range(1, blk_size[k]);
                end else if (r < 70) begin
                    size = $urandom_range(1, 64);
                end else if (r < 85) begin
                    size = $urandom_range(65, 4096);
                end else if (r < 92) begin
                    size = $urandom_range(4097, 32'h00FF_FFFF);
                end else if (r < 96) begin
                    size = {1'b1, 31'($urandom)};
                end else begin
                    size = '0;
                end
                send_req(REQ_ALLOC, size, addr);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 55 && held.size() > 0) begin
                    addr = payload_at(held[$urandom_range(0, held.size() - 1)]);
                end else if (r < 70 && freed.size() > 0) begin
                    addr = payload_at(freed[$urandom_range(0, freed.size() - 1)]);
                end else if (r < 80) begin
                    addr = '0;
                end else if (r < 88 && blk_count > 0) begin
                    // near miss: inside a header or payload, not on its start
                    addr = payload_at($urandom_range(0, blk_count - 1))
                           + ADDR_W'($urandom_range(1, HEADER_BYTES - 1));
                end
                send_req(REQ_RELEASE, size, addr);
            end
            if (j % 150 == 149) wait_drain();
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Empty table at reset values: null release, stray release, zero size,
    // then no room under a zero limit and past the end of the address space
    task automatic test_empty_heap();
        send_req(REQ_RELEASE, 32'h0000_0000, 32'h0000_0000);
        send_req(REQ_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_ALLOC,   32'h0000_0000, 32'hFFFF_FFFF);
        write_reg(CFG_HEAP_LIMIT, 32'h0000_0000);
        send_req(REQ_ALLOC,   32'h0000_0001, 32'h0000_0000);
        write_reg(CFG_HEAP_BASE,  32'hFFFF_FFFF);
        write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        send_req(REQ_ALLOC,   32'h0000_0001, 32'h0000_0000);
        write_reg(CFG_HEAP_BASE,  32'h0000_1000);
    endtask

    // Appends, release, double release, near miss and first-fit reuse
    task automatic test_first_fit();
        send_req(REQ_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
        send_req(REQ_ALLOC, 32'd1,   32'h0);
        send_req(REQ_ALLOC, 32'd100, 32'h0);
        send_req(REQ_ALLOC, 32'd40,  32'h0);
        send_req(REQ_RELEASE, 32'h0, payload_at(1));
        send_req(REQ_RELEASE, 32'h0, payload_at(1));
        send_req(REQ_RELEASE, 32'h0, payload_at(1) + 32'd1);
        send_req(REQ_ALLOC, 32'd50,  32'h0);
        send_req(REQ_RELEASE, 32'h0, payload_at(0));
        send_req(REQ_RELEASE, 32'h0, payload_at(2));
        // neither freed block fits, so append; then skip the 1-byte block
        send_req(REQ_ALLOC, 32'd41,  32'h0);
        send_req(REQ_ALLOC, 32'd40,  32'h0);
        send_req(REQ_ALLOC, 32'd1,   32'h0);
    endtask

    // Limit hit exactly, then a one-byte allocate past it; a base write with a
    // populated table must leave the heap top where it is
    task automatic test_limit_edge();
        write_reg(CFG_HEAP_LIMIT, heap_top_q[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES) + 32'd7);
        send_req(REQ_ALLOC, 32'd8, 32'h0);
        send_req(REQ_ALLOC, 32'd1, 32'h0);
        write_reg(CFG_HEAP_BASE,  32'h0000_0000);
        write_reg(CFG_HEAP_LIMIT, 32'h7FFF_FFFF);
        send_req(REQ_ALLOC, 32'd1, 32'h0);
    endtask

    // Table fills up while blocks are churned
    task automatic test_growth();
        random_requests(300);
    endtask

    // Heap almost exhausted: heap and table failures compete
    task automatic test_tight_limit();
        write_reg(CFG_HEAP_LIMIT, heap_top_q[ADDR_W-1:0] + 32'h0000_0800);
        random_requests(300);
    endtask

    // Full address space again, a stretch with no gaps, then gaps
    task automatic test_full_churn();
        write_reg(CFG_HEAP_BASE,  32'hFFFF_FFFF);
        write_reg(CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
        no_gaps = 1'b1;
        random_requests(100);
        wait_drain();
        no_gaps = 1'b0;
        random_requests(200);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls and the beat check
    // -----------------------------------------------------------------------

    function automatic bit field_ok(string what, logic [31:0] want, logic [31:0] got);
        if (want === got) return 1'b1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        return 1'b0;
    endfunction

    task automatic check_result(logic [OUT_DATA_W-1:0] beat);
        outcome_t want;
        bit       ok;
        results_seen++;
        if (outcome_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %0h", $time, beat);
            err_count++;
        end else begin
            want = outcome_q.pop_front();
            ok   = field_ok("status", 32'(want.status), 32'(beat[2:0]));
            ok  &= field_ok("payload_address", want.payload, beat[34:3]);
            ok  &= field_ok("block_tag", 32'(want.tag), 32'(beat[36:35]));
            ok  &= field_ok("alloc_total", want.alloc_total, beat[68:37]);
            ok  &= field_ok("release_total", want.release_total, beat[100:69]);
            ok  &= field_ok("leak_total", want.leak_total, beat[132:101]);
            if (!ok) err_count++;
            status_seen[want.status]++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            // hold off for a random stretch, otherwise accept
            if (stall_left > 0) begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                stall_left <= idle_len();
                m_tready   <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: run timed out after %0d cycles", $time, cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        heap_base_q  = '0;
        heap_limit_q = '1;
        heap_top_q   = '0;
        blk_count    = 0;
        allocs_q     = '0;
        releases_q   = '0;
        no_gaps      = 1'b0;
        err_count    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_heap();
        test_first_fit();
        test_limit_edge();
        test_growth();
        test_tight_limit();
        test_full_churn();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests and %0d results; table peaked at %0d of %0d blocks.",
                 requests_sent, results_seen, blk_count, MAX_BLOCKS);
        $display("Outcomes: ok %0d, zero size %0d, heap %0d, table %0d, unknown %0d, twice %0d.",
                 status_seen[ST_OK], status_seen[ST_ZERO], status_seen[ST_HEAP],
                 status_seen[ST_TABLE], status_seen[ST_UNKNOWN], status_seen[ST_TWICE]);
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### first_fit_block_allocator.f
rtl/ffba_pkg.sv
rtl/ffba_table.sv
rtl/ffba_scan.sv
rtl/first_fit_block_allocator.sv
bench/testbench.sv
